FILE: hdl/lpnal_pkg.sv
// shared types and constants for the length-prefixed nal to start-code converter
package lpnal_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int BURST_MAX           = 5;
   localparam int BURST_COUNT_BITS    = $clog2(BURST_MAX + 1);
   localparam int FIFO_DEPTH          = 16;
   localparam int FIFO_ADDR_BITS      = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_BITS     = $clog2(FIFO_DEPTH + 1);
   localparam int PREFIX_BYTES        = 4;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] MODE_PASS    = 3'd0;
   localparam logic [2:0] MODE_CONVERT = 3'd4;

   localparam logic [2:0] HEADER_FULL = 3'd4;

   localparam logic [0:0] CSR_IDX_LENGTH_FIELD_SIZE = 1'b0;

   localparam logic [31:0] START_CODE = 32'h0000_0001;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       no_byte;
      logic       overrun;
      logic       merr;
   } rsp_beat_type;

   typedef struct packed {
      logic [BURST_COUNT_BITS-1:0]     count;
      rsp_beat_type [BURST_MAX-1:0]    beat;
   } rsp_burst_type;

endpackage

FILE: hdl/lpnal_csr.sv
// configuration register block: length field size register on an apb-style port
module lpnal_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lpnal_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [lpnal_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [lpnal_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready,
   output logic [2:0]                          length_field_size
);
   import lpnal_pkg::*;

   logic [2:0] length_field_size_ff;
   logic [2:0] length_field_size_in;
   logic       wr_en;
   logic       hit;

   assign pready = 1'b1;
   assign hit    = (paddr[CSR_ADDR_BITS-1 -: 1] == CSR_IDX_LENGTH_FIELD_SIZE);
   assign wr_en  = psel & penable & pwrite & pready & hit;

   always_comb begin
      length_field_size_in = length_field_size_ff;
      if (wr_en) begin
         length_field_size_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_field_size_ff <= MODE_PASS;
      end else begin
         length_field_size_ff <= length_field_size_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit) begin
         prdata = {{(CSR_DATA_BITS-3){1'b0}}, length_field_size_ff};
      end
   end

   assign length_field_size = length_field_size_ff;

endmodule

FILE: hdl/lpnal_step.sv
// per-byte conversion logic and packet parsing state
module lpnal_step #(
   parameter int LENGTH_BITS = lpnal_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0]               length_field_size,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output lpnal_pkg::rsp_burst_type burst
);
   import lpnal_pkg::*;

   logic [2:0]             header_count_ff, header_count_in;
   logic [31:0]            length_shift_ff, length_shift_in;
   logic [LENGTH_BITS-1:0] payload_left_ff, payload_left_in;
   logic                   in_payload_ff, in_payload_in;
   logic                   passing_through_ff, passing_through_in;

   logic [LENGTH_BITS-1:0] len_clamp;
   logic                   merr;
   logic                   overrun;
   rsp_burst_type          bst;

   if (LENGTH_BITS < 32) begin : g_clamp
      assign len_clamp = (|length_shift_ff[31:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                             : length_shift_ff[LENGTH_BITS-1:0];
   end else begin : g_full
      assign len_clamp = length_shift_ff[LENGTH_BITS-1:0];
   end

   always_comb begin
      header_count_in    = header_count_ff;
      length_shift_in    = length_shift_ff;
      payload_left_in    = payload_left_ff;
      in_payload_in      = in_payload_ff;
      passing_through_in = passing_through_ff;
      merr               = (length_field_size != MODE_PASS) &&
                           (length_field_size != MODE_CONVERT);
      overrun            = 1'b0;
      bst                = '0;

      for (int k = 0; k < BURST_MAX; k++) begin
         bst.beat[k].merr = merr;
      end

      if (in_valid) begin
         case (length_field_size)
            MODE_PASS: begin
               bst.beat[0].data = in_byte;
               bst.count        = BURST_COUNT_BITS'(1);
            end
            MODE_CONVERT: begin
               if (in_payload_ff) begin
                  bst.beat[0].data = in_byte;
                  bst.count        = BURST_COUNT_BITS'(1);
                  payload_left_in  = payload_left_ff - 1'b1;
                  if (payload_left_in == '0) begin
                     in_payload_in   = 1'b0;
                     header_count_in = '0;
                  end
               end else if (header_count_ff < HEADER_FULL) begin
                  length_shift_in = {length_shift_ff[23:0], in_byte};
                  header_count_in = header_count_ff + 1'b1;
               end else begin
                  for (int k = 0; k < PREFIX_BYTES; k++) begin
                     bst.beat[k].data = START_CODE[31 - 8*k -: 8];
                  end
                  if (len_clamp == '0) begin
                     bst.count       = BURST_COUNT_BITS'(PREFIX_BYTES);
                     length_shift_in = {24'd0, in_byte};
                     header_count_in = 3'd1;
                  end else begin
                     bst.beat[PREFIX_BYTES].data = in_byte;
                     bst.count       = BURST_COUNT_BITS'(BURST_MAX);
                     payload_left_in = len_clamp - 1'b1;
                     header_count_in = '0;
                     in_payload_in   = (payload_left_in != '0);
                  end
               end
               overrun = in_payload_in && (payload_left_in != '0);
            end
            default: begin
               if (passing_through_ff) begin
                  bst.beat[0].data = in_byte;
                  bst.count        = BURST_COUNT_BITS'(1);
               end else if (header_count_ff < HEADER_FULL) begin
                  length_shift_in = {length_shift_ff[23:0], in_byte};
                  header_count_in = header_count_ff + 1'b1;
               end else begin
                  for (int k = 0; k < PREFIX_BYTES; k++) begin
                     bst.beat[k].data = length_shift_ff[31 - 8*k -: 8];
                  end
                  bst.beat[PREFIX_BYTES].data = in_byte;
                  bst.count          = BURST_COUNT_BITS'(BURST_MAX);
                  header_count_in    = '0;
                  length_shift_in    = '0;
                  passing_through_in = 1'b1;
               end
            end
         endcase

         if (in_last) begin
            if (bst.count == '0) begin
               bst.beat[0].data    = 8'd0;
               bst.beat[0].no_byte = 1'b1;
               bst.count           = BURST_COUNT_BITS'(1);
            end
            for (int k = 0; k < BURST_MAX; k++) begin
               if (bst.count == BURST_COUNT_BITS'(k + 1)) begin
                  bst.beat[k].last    = 1'b1;
                  bst.beat[k].overrun = overrun;
               end
            end
            header_count_in    = '0;
            length_shift_in    = '0;
            payload_left_in    = '0;
            in_payload_in      = 1'b0;
            passing_through_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff    <= '0;
         length_shift_ff    <= '0;
         payload_left_ff    <= '0;
         in_payload_ff      <= 1'b0;
         passing_through_ff <= 1'b0;
      end else begin
         header_count_ff    <= header_count_in;
         length_shift_ff    <= length_shift_in;
         payload_left_ff    <= payload_left_in;
         in_payload_ff      <= in_payload_in;
         passing_through_ff <= passing_through_in;
      end
   end

   assign burst = bst;

   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HEADER_FULL)
      else $error("prefix byte count out of range");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (payload_left_ff != '0))
      else $error("inside a unit with no payload left");

   a_packet_end_clears: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_last) |=>
         (header_count_ff == '0 && !in_payload_ff && !passing_through_ff))
      else $error("state not cleared after packet end");

   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_last) |-> (bst.count != '0))
      else $error("packet end produced no beat");

endmodule

FILE: hdl/lpnal_fifo.sv
// result queue: takes a burst of up to five beats per cycle, delivers one beat per cycle while head_ready is high
module lpnal_fifo (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lpnal_pkg::rsp_burst_type              burst,
   output lpnal_pkg::rsp_beat_type               head,
   output logic                                  head_valid,
   input  logic                                  head_ready,
   output logic [lpnal_pkg::FIFO_COUNT_BITS-1:0] count
);
   import lpnal_pkg::*;

   rsp_beat_type                mem [FIFO_DEPTH];
   logic [FIFO_ADDR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_ADDR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_BITS-1:0]  count_ff, count_in;
   logic                        pop;

   assign head_valid = (count_ff != '0);
   assign pop        = head_valid & head_ready;
   assign head       = mem[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_ADDR_BITS'(burst.count);
      rd_ptr_in = rd_ptr_ff + FIFO_ADDR_BITS'(pop);
      count_in  = count_ff + FIFO_COUNT_BITS'(burst.count) - FIFO_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BURST_MAX; k++) begin
         if (BURST_COUNT_BITS'(k) < burst.count) begin
            mem[wr_ptr_ff + FIFO_ADDR_BITS'(k)] <= burst.beat[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + (FIFO_COUNT_BITS+1)'(burst.count)) <=
         (FIFO_COUNT_BITS+1)'(FIFO_DEPTH))
      else $error("burst written into a full queue");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == rd_ptr_ff + FIFO_ADDR_BITS'(count_ff))
      else $error("queue pointers disagree with fill count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_COUNT_BITS'(FIFO_DEPTH))
      else $error("fill count beyond depth");

endmodule

FILE: hdl/length_prefixed_nal_to_start_code.sv
// top level: length-prefixed nal unit to start-code converter
//
// bytes of a packet enter on the req channel (valid/ready), the final byte
// marked by req_packet_end. with length_field_size = 4 each unit's 4-byte
// big-endian length is swallowed and replaced by 00 00 00 01; with 0 bytes
// pass unchanged; any other size passes bytes with rsp_mode_error set.
// results leave on the rsp channel, one beat per cycle while rsp_ready is
// high; a byte yields zero to five beats. the last beat of a packet carries
// rsp_out_last, and rsp_length_overrun when the final unit was cut short by
// the packet end. a byte is registered, converted in the next cycle and
// written to a 16-beat result queue whose head drives the rsp channel.
// throughput: one byte per cycle while the queue has room for the burst
// still in flight plus a full five-beat burst; sustained rate is set by the
// one-beat-per-cycle read port of that queue. a stalled receiver fills the
// queue and then req_ready drops; nothing is lost.
// synchronous reset empties the queue, clears the parsing state and sets
// length_field_size to 0.
// the register sits at byte address 0 of the apb-style port.
module length_prefixed_nal_to_start_code #(
   parameter int LENGTH_BITS = lpnal_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_packet_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_out_last,
   output logic                                rsp_no_byte,
   output logic                                rsp_length_overrun,
   output logic                                rsp_mode_error,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lpnal_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [lpnal_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [lpnal_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);
   import lpnal_pkg::*;

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       in_last_ff;
   logic [2:0]                 length_field_size;
   rsp_burst_type              burst;
   rsp_beat_type               head;
   logic [FIFO_COUNT_BITS-1:0] fifo_count;
   logic [FIFO_COUNT_BITS:0]   committed;
   logic                       req_fire;

   lpnal_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .length_field_size (length_field_size)
   );

   // worst case: queued beats plus a full burst for the byte in flight
   assign committed = {1'b0, fifo_count} +
                      ((FIFO_COUNT_BITS+1)'(BURST_MAX) & {(FIFO_COUNT_BITS+1){in_valid_ff}});
   assign req_ready = (committed <= (FIFO_COUNT_BITS+1)'(FIFO_DEPTH - BURST_MAX));
   assign req_fire  = req_valid & req_ready;
   assign in_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_packet_end;
      end
   end

   lpnal_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .clock             (clock),
      .reset             (reset),
      .length_field_size (length_field_size),
      .in_valid          (in_valid_ff),
      .in_byte           (in_byte_ff),
      .in_last           (in_last_ff),
      .burst             (burst)
   );

   lpnal_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .head       (head),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready),
      .count      (fifo_count)
   );

   assign rsp_out_byte       = head.data;
   assign rsp_out_last       = head.last;
   assign rsp_no_byte        = head.no_byte;
   assign rsp_length_overrun = head.overrun;
   assign rsp_mode_error     = head.merr;

endmodule

FILE: test/length_prefixed_nal_to_start_code_test.sv
// testbench for the length-prefixed nal to start-code converter: directed table, random packets
module length_prefixed_nal_to_start_code_test;
   import lpnal_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 8;
   localparam int HOLD_CYCLES   = 90;
   localparam int PRINT_LIMIT   = 40;
   localparam int PAYLOAD_BITS  = LENGTH_BITS_DEFAULT;
   localparam longint unsigned MAX_DECLARED = (64'd1 << PAYLOAD_BITS) - 1;
   localparam logic [CSR_ADDR_BITS-1:0] SIZE_REG_ADDR =
      CSR_ADDR_BITS'({CSR_IDX_LENGTH_FIELD_SIZE, 2'b00});

   localparam logic [2:0] MODE_BAD_1 = 3'd1;
   localparam logic [2:0] MODE_BAD_2 = 3'd2;
   localparam logic [2:0] MODE_BAD_3 = 3'd3;
   localparam logic [2:0] MODE_BAD_5 = 3'd5;
   localparam logic [2:0] MODE_BAD_6 = 3'd6;
   localparam logic [2:0] MODE_BAD_7 = 3'd7;

   localparam int N_PHASES = 14;
   localparam logic [2:0] PHASE_MODES [N_PHASES] = '{
      MODE_CONVERT, MODE_PASS, MODE_CONVERT, MODE_BAD_1, MODE_CONVERT, MODE_BAD_2, MODE_BAD_5,
      MODE_CONVERT, MODE_BAD_6, MODE_BAD_7, MODE_CONVERT, MODE_BAD_3, MODE_PASS, MODE_CONVERT};

   typedef enum logic [1:0] {ROW_BYTE, ROW_SIZE} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [7:0]    data;
      logic          last;
      row_check_type chk;
      rsp_beat_type  want;
   } stim_row_type;

   localparam int DIR_ROWS = 29;
   localparam stim_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      // passthrough after reset
      '{ROW_BYTE, 8'hFF, 1'b0, CHK_ONE, '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'h00, 1'b1, CHK_ONE, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
      // bad size, one-byte packet is dropped
      '{ROW_SIZE, {5'd0, MODE_BAD_7}, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'hA5, 1'b1, CHK_ONE, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1}},
      // convert: empty end
      '{ROW_SIZE, {5'd0, MODE_CONVERT}, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b1, CHK_ONE, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
      // one-byte unit then a short tail
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h01, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h7E, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h01, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h02, 1'b1, CHK_ONE, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
      // zero-length unit, then a unit cut by the packet end
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h03, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'hAB, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'hCD, 1'b1, CHK_MODEL, '0},
      // size changes in the middle of a packet
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0},
      '{ROW_SIZE, {5'd0, MODE_BAD_3}, 1'b0, CHK_NONE, '0},
      '{ROW_BYTE, 8'h12, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h34, 1'b0, CHK_MODEL, '0},
      '{ROW_BYTE, 8'h56, 1'b1, CHK_MODEL, '0}};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     req_packet_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic                     rsp_out_last;
   logic                     rsp_no_byte;
   logic                     rsp_length_overrun;
   logic                     rsp_mode_error;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // predictor state
   logic [2:0]              size_reg = MODE_PASS;
   logic [2:0]              header_count = '0;
   logic [31:0]             length_shift = '0;
   logic [PAYLOAD_BITS-1:0] payload_left = '0;
   logic                    in_payload = 1'b0;
   logic                    passing_through = 1'b0;
   rsp_beat_type            byte_burst [BURST_MAX];
   int                      burst_len;

   rsp_beat_type pending_beats [$];
   int           error_count = 0;
   int           beats_seen = 0;
   int           bytes_sent = 0;
   int           packets_sent = 0;
   int           size_writes = 0;
   int           cycle_count = 0;
   bit           send_quiet = 1'b0;
   bit           recv_quiet = 1'b0;
   bit           hold_request = 1'b0;

   length_prefixed_nal_to_start_code i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_packet_end     (req_packet_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_last       (rsp_out_last),
      .rsp_no_byte        (rsp_no_byte),
      .rsp_length_overrun (rsp_length_overrun),
      .rsp_mode_error     (rsp_mode_error),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  pending_beats.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at beat %0d: %s got %0h want %0h", beats_seen, what, got, want);
   endtask

   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 24) == 0)
         quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic void add_beat(input logic [7:0] d, input logic merr);
      byte_burst[burst_len] = '{d, 1'b0, 1'b0, 1'b0, merr};
      burst_len++;
   endfunction

   function automatic void clear_parser();
      header_count    = '0;
      length_shift    = '0;
      payload_left    = '0;
      in_payload      = 1'b0;
      passing_through = 1'b0;
   endfunction

   // beats produced by one packet byte under the current size register
   function automatic void convert_byte(input logic [7:0] b, input logic l);
      logic            merr;
      logic            cut;
      longint unsigned len;
      int              k;
      merr = (size_reg != MODE_PASS) && (size_reg != MODE_CONVERT);
      cut = 1'b0;
      burst_len = 0;
      if (size_reg == MODE_PASS) begin
         add_beat(b, 1'b0);
      end else if (size_reg == MODE_CONVERT) begin
         if (in_payload) begin
            add_beat(b, 1'b0);
            payload_left = payload_left - 1'b1;
            if (payload_left == 0) begin
               in_payload   = 1'b0;
               header_count = '0;
            end
         end else if (header_count < HEADER_FULL) begin
            length_shift = {length_shift[23:0], b};
            header_count++;
         end else begin
            for (k = 0; k < PREFIX_BYTES; k++)
               add_beat(START_CODE[31-8*k -: 8], 1'b0);
            len = length_shift;
            if (len > MAX_DECLARED)
               len = MAX_DECLARED;
            if (len == 0) begin
               length_shift = {24'd0, b};
               header_count = 3'd1;
            end else begin
               add_beat(b, 1'b0);
               payload_left = PAYLOAD_BITS'(len - 1);
               header_count = '0;
               in_payload   = payload_left != 0;
            end
         end
         cut = in_payload && (payload_left != 0);
      end else begin
         if (passing_through) begin
            add_beat(b, merr);
         end else if (header_count < HEADER_FULL) begin
            length_shift = {length_shift[23:0], b};
            header_count++;
         end else begin
            for (k = 0; k < PREFIX_BYTES; k++)
               add_beat(length_shift[31-8*k -: 8], merr);
            add_beat(b, merr);
            header_count    = '0;
            length_shift    = '0;
            passing_through = 1'b1;
         end
      end
      if (l) begin
         if (burst_len == 0) begin
            add_beat(8'h00, merr);
            byte_burst[0].no_byte = 1'b1;
         end
         byte_burst[burst_len-1].last    = 1'b1;
         byte_burst[burst_len-1].overrun = cut;
         clear_parser();
      end
   endfunction

   task automatic wait_idle(input int settle);
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_length_size(input logic [2:0] v);
      req_valid <= 1'b0;
      wait_idle(SETTLE_CYCLES);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= SIZE_REG_ADDR;
      pwdata  <= CSR_DATA_BITS'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[2:0] !== v)
         report_mismatch("length_field_size readback", 8'(prdata[2:0]), 8'(v));
      psel    <= 1'b0;
      penable <= 1'b0;
      size_reg = v;
      size_writes++;
   endtask

   task automatic send_byte(input logic [7:0] d, input logic l, input row_check_type chk,
                            input rsp_beat_type want);
      int gap;
      int k;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= d;
      req_packet_end <= l;
      do @(posedge clock); while (req_ready !== 1'b1);
      convert_byte(d, l);
      case (chk)
         CHK_MODEL: begin
            for (k = 0; k < burst_len; k++)
               pending_beats.push_back(byte_burst[k]);
         end
         CHK_ONE: pending_beats.push_back(want);
         default: ;
      endcase
      bytes_sent++;
      if (l)
         packets_sent++;
   endtask

   task automatic send_random_packet(input logic [2:0] m);
      logic [7:0]  pkt [$];
      logic [31:0] len;
      int          units;
      int          body;
      int          keep;
      int          u;
      int          k;
      if (m != MODE_CONVERT || $urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
      end else begin
         units = $urandom_range(1, 3);
         for (u = 0; u < units; u++) begin
            k = $urandom_range(0, 99);
            if (k < 60)
               len = $urandom_range(0, 6);
            else if (k < 90)
               len = $urandom_range(7, 24);
            else
               len = $urandom;
            for (k = 0; k < PREFIX_BYTES; k++)
               pkt.push_back(len[31-8*k -: 8]);
            body = (len > 24) ? $urandom_range(0, 6) : int'(len);
            repeat (body) pkt.push_back(8'($urandom));
            if (len > 24)
               break;
         end
         // short tail
         if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
         // broken packet: cut anywhere
         if ($urandom_range(0, 99) < 10) begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep)
               void'(pkt.pop_back());
         end
      end
      for (k = 0; k < pkt.size(); k++)
         send_byte(pkt[k], k == pkt.size() - 1, CHK_MODEL, '0);
   endtask

   task automatic check_beat();
      rsp_beat_type want;
      beats_seen++;
      if (pending_beats.size() == 0) begin
         report_mismatch("unexpected beat, out_byte", rsp_out_byte, 8'h00);
         return;
      end
      want = pending_beats.pop_front();
      if (rsp_out_byte !== want.data)
         report_mismatch("out_byte", rsp_out_byte, want.data);
      if (rsp_out_last !== want.last)
         report_mismatch("out_last", 8'(rsp_out_last), 8'(want.last));
      if (rsp_no_byte !== want.no_byte)
         report_mismatch("no_byte", 8'(rsp_no_byte), 8'(want.no_byte));
      if (rsp_length_overrun !== want.overrun)
         report_mismatch("length_overrun", 8'(rsp_length_overrun), 8'(want.overrun));
      if (rsp_mode_error !== want.merr)
         report_mismatch("mode_error", 8'(rsp_mode_error), 8'(want.merr));
   endtask

   initial begin : result_side
      int idle;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            idle = HOLD_CYCLES;
         end else begin
            idle = draw_wait(recv_quiet);
         end
         if (idle > 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_beat();
      end
   end

   initial begin : byte_side
      int r;
      int p;
      int budget;
      int first;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_SIZE)
            write_length_size(DIRECTED_ROWS[r].data[2:0]);
         else
            send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].chk,
                      DIRECTED_ROWS[r].want);
      end
      for (p = 0; p < N_PHASES; p++) begin
         write_length_size(PHASE_MODES[p]);
         // long receiver stall while bytes keep coming
         if (p == 0 || p == 7)
            hold_request = 1'b1;
         budget = (PHASE_MODES[p] == MODE_CONVERT) ? 34 : 16;
         first = bytes_sent;
         while (bytes_sent - first < budget)
            send_random_packet(PHASE_MODES[p]);
      end
      req_valid <= 1'b0;
      wait_idle(END_CYCLES);
      $display("covered %0d bytes in %0d packets, %0d result beats, %0d size register writes",
               bytes_sent, packets_sent, beats_seen, size_writes);
      $display("sizes passthrough, convert and all error values, %0d mismatches", error_count);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: length_prefixed_nal_to_start_code.f
hdl/lpnal_pkg.sv
hdl/lpnal_csr.sv
hdl/lpnal_step.sv
hdl/lpnal_fifo.sv
hdl/length_prefixed_nal_to_start_code.sv
test/length_prefixed_nal_to_start_code_test.sv
